FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; every macro disables on an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/sprblt_pkg.sv
// shared types and constants of the scaled sprite blit unit
// no dependencies
package sprblt_pkg;

	// default parameter values
	localparam int MAX_ZOOM_DEF       = 8;
	localparam int MAX_SPRITE_DIM_DEF = 256;
	localparam int SCREEN_DIM_DEF     = 4096;
	localparam int QUEUE_DEPTH        = 4;

	// field widths
	localparam int COLOR_W  = 32;
	localparam int PIX_W    = 12;
	localparam int ORIGIN_W = 13;
	localparam int ZOOM_W   = 4;
	localparam int SCREEN_W = 13;
	localparam int SPRITE_W = 9;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 3;

	// internal widths: signed screen coordinates, sprite position compares,
	// in-square offsets (zoom never above 8)
	localparam int COORD_W = 16;
	localparam int POS_W   = 12;
	localparam int SPAN_W  = 3;

	// alpha byte position and mask
	localparam int          ALPHA_SHIFT = 24;
	localparam logic [7:0]  ALPHA_MASK  = 8'hFF;

	// register reset values
	localparam logic signed [ORIGIN_W-1:0] ORIGIN_RST = '0;
	localparam logic [ZOOM_W-1:0]          ZOOM_RST   = 4'd1;
	localparam logic [SCREEN_W-1:0]        SCR_W_RST  = 13'd640;
	localparam logic [SCREEN_W-1:0]        SCR_H_RST  = 13'd480;
	localparam logic [SPRITE_W-1:0]        SPR_W_RST  = 9'd64;
	localparam logic [SPRITE_W-1:0]        SPR_H_RST  = 9'd64;

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_ZOOM          = 3'd2,
		REG_SCREEN_WIDTH  = 3'd3,
		REG_SCREEN_HEIGHT = 3'd4,
		REG_SPRITE_WIDTH  = 3'd5,
		REG_SPRITE_HEIGHT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] origin_x;
		logic signed [ORIGIN_W-1:0] origin_y;
		logic [ZOOM_W-1:0]          zoom;
		logic [SCREEN_W-1:0]        screen_width;
		logic [SCREEN_W-1:0]        screen_height;
		logic [SPRITE_W-1:0]        sprite_width;
		logic [SPRITE_W-1:0]        sprite_height;
	} cfg_t;

	// one visible rectangle of writes, queued from front to back
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [PIX_W-1:0]   start_x;
		logic [PIX_W-1:0]   start_y;
		logic [SPAN_W-1:0]  span_x;
		logic [SPAN_W-1:0]  span_y;
	} entry_t;

endpackage

FILE: hw/rtl/sprblt_front.sv
// front end: accepts texels, tracks sprite position, clips the square
// depends on sprblt_pkg
module sprblt_front #(
	parameter int MAX_ZOOM       = sprblt_pkg::MAX_ZOOM_DEF,
	parameter int MAX_SPRITE_DIM = sprblt_pkg::MAX_SPRITE_DIM_DEF,
	parameter int SCREEN_DIM     = sprblt_pkg::SCREEN_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sprblt_pkg::cfg_t                    cfg,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sprblt_pkg::COLOR_W-1:0]      texel_color,
	output logic                                push,
	output sprblt_pkg::entry_t                  push_data,
	input  logic                                full
);
	import sprblt_pkg::*;

	localparam int COL_W = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;

	typedef struct packed {
		logic              ok;
		logic [PIX_W-1:0]  start;
		logic [SPAN_W-1:0] span;
	} range_t;

	logic [COL_W-1:0]          col_q, row_q;
	logic [ZOOM_W-1:0]         z;
	logic [POS_W-1:0]          sw, sh;
	logic                      take;
	logic [COORD_W-1:0]        prod_x, prod_y;
	logic signed [COORD_W-1:0] base_x, base_y;
	logic signed [COORD_W-1:0] clip_w, clip_h, zm1;

	logic                      valid_s1, opaque_s1;
	logic [COLOR_W-1:0]        color_s1;
	logic signed [COORD_W-1:0] base_x_s1, base_y_s1;

	range_t rx, ry;
	logic   need_push, blocked;

	// visible offsets [lo, hi] of one axis in [0, zoom-1], pixels in [0, clip)
	function automatic range_t axis_range(input logic signed [COORD_W-1:0] base,
			input logic signed [COORD_W-1:0] clip, input logic signed [COORD_W-1:0] zmax);
		logic signed [COORD_W-1:0] lo, hi, lim;
		range_t r;
		lo = (base < 0) ? -base : '0;
		lim = clip - COORD_W'(1) - base;
		hi = (lim < zmax) ? lim : zmax;
		r.ok = (lo <= hi);
		r.start = PIX_W'(base + lo);
		r.span = SPAN_W'(hi - lo);
		return r;
	endfunction

	always_comb begin
		z = cfg.zoom;
		if (cfg.zoom == '0) begin
			z = ZOOM_W'(1);
		end else if (cfg.zoom > ZOOM_W'(MAX_ZOOM)) begin
			z = ZOOM_W'(MAX_ZOOM);
		end
		sw = POS_W'(cfg.sprite_width);
		if (sw == '0) begin
			sw = POS_W'(1);
		end else if (sw > POS_W'(MAX_SPRITE_DIM)) begin
			sw = POS_W'(MAX_SPRITE_DIM);
		end
		sh = POS_W'(cfg.sprite_height);
		if (sh == '0) begin
			sh = POS_W'(1);
		end else if (sh > POS_W'(MAX_SPRITE_DIM)) begin
			sh = POS_W'(MAX_SPRITE_DIM);
		end
	end

	assign prod_x = COORD_W'(col_q) * COORD_W'(z);
	assign prod_y = COORD_W'(row_q) * COORD_W'(z);
	assign base_x = COORD_W'(cfg.origin_x) + $signed(prod_x);
	assign base_y = COORD_W'(cfg.origin_y) + $signed(prod_y);

	assign clip_w = (COORD_W'(cfg.screen_width) < COORD_W'(SCREEN_DIM))
		? $signed(COORD_W'(cfg.screen_width)) : $signed(COORD_W'(SCREEN_DIM));
	assign clip_h = (COORD_W'(cfg.screen_height) < COORD_W'(SCREEN_DIM))
		? $signed(COORD_W'(cfg.screen_height)) : $signed(COORD_W'(SCREEN_DIM));
	assign zm1 = $signed(COORD_W'(z)) - COORD_W'(1);

	assign rx = axis_range(base_x_s1, clip_w, zm1);
	assign ry = axis_range(base_y_s1, clip_h, zm1);

	assign need_push = valid_s1 && opaque_s1 && rx.ok && ry.ok;
	assign blocked   = need_push && full;
	assign in_stall  = blocked;
	assign take      = in_valid && !blocked;
	assign push      = need_push && !full;

	always_comb begin
		push_data.color   = color_s1;
		push_data.start_x = rx.start;
		push_data.start_y = ry.start;
		push_data.span_x  = rx.span;
		push_data.span_y  = ry.span;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (!blocked) begin
				valid_s1 <= take;
			end
			if (take) begin
				if (POS_W'(col_q) + POS_W'(1) >= sw) begin
					col_q <= '0;
					if (POS_W'(row_q) + POS_W'(1) >= sh) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + COL_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			color_s1  <= texel_color;
			opaque_s1 <= ((texel_color >> ALPHA_SHIFT) & COLOR_W'(ALPHA_MASK)) == '0;
			base_x_s1 <= base_x;
			base_y_s1 <= base_y;
		end
	end

endmodule

FILE: hw/rtl/sprblt_fifo.sv
// small register queue between front and back
// depends on nothing; width and depth are parameters
module sprblt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: hw/rtl/sprblt_back.sv
// back end: walks each queued rectangle and drives the output register
// depends on sprblt_pkg
module sprblt_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sprblt_pkg::entry_t             rd_data,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sprblt_pkg::PIX_W-1:0]   pixel_x,
	output logic [sprblt_pkg::PIX_W-1:0]   pixel_y,
	output logic [sprblt_pkg::COLOR_W-1:0] pixel_color,
	output logic                           run_last
);
	import sprblt_pkg::*;

	entry_t            cur_q;
	logic              busy_q;
	logic [SPAN_W-1:0] cx_q, cy_q;
	logic              out_valid_q;
	logic              emit, last;

	assign emit = busy_q && (!out_valid_q || !out_stall);
	assign last = (cx_q == cur_q.span_x) && (cy_q == cur_q.span_y);
	assign pop  = !empty && (!busy_q || (emit && last));

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			cx_q <= '0;
			cy_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				cx_q <= '0;
				cy_q <= '0;
			end else if (emit) begin
				if (last) begin
					busy_q <= 1'b0;
				end else if (cx_q == cur_q.span_x) begin
					cx_q <= '0;
					cy_q <= cy_q + SPAN_W'(1);
				end else begin
					cx_q <= cx_q + SPAN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_data;
		end
		if (emit) begin
			pixel_x     <= cur_q.start_x + PIX_W'(cx_q);
			pixel_y     <= cur_q.start_y + PIX_W'(cy_q);
			pixel_color <= cur_q.color;
			run_last    <= last;
		end
	end

endmodule

FILE: hw/rtl/scaled_sprite_blit_unit.sv
// top level of the scaled sprite blit unit: config registers, front, queue, back
// depends on sprblt_pkg, sprblt_front, sprblt_fifo, sprblt_back
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | texel_color
//  output   | out_valid / out_stall| pixel_x, pixel_y, pixel_color, run_last
//  config   | cfg_write_en         | cfg_index, cfg_data
//
// the front registers each accepted texel; the back issues one write per cycle
// while out_stall is low, so the single write port of the back sets the pace
// of visible texels; an unclipped opaque texel makes zoom*zoom writes
// a texel's writes pass the front stage, queue, rectangle and output registers
// a four-entry queue lets the front keep taking texels while the output stalls
// reset clears position, queue and valid flags; registers return to defaults
module scaled_sprite_blit_unit #(
	parameter int MAX_ZOOM       = sprblt_pkg::MAX_ZOOM_DEF,
	parameter int MAX_SPRITE_DIM = sprblt_pkg::MAX_SPRITE_DIM_DEF,
	parameter int SCREEN_DIM     = sprblt_pkg::SCREEN_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [sprblt_pkg::IDX_W-1:0]   cfg_index,
	input  logic [sprblt_pkg::CFG_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sprblt_pkg::COLOR_W-1:0] texel_color,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sprblt_pkg::PIX_W-1:0]   pixel_x,
	output logic [sprblt_pkg::PIX_W-1:0]   pixel_y,
	output logic [sprblt_pkg::COLOR_W-1:0] pixel_color,
	output logic                           run_last
);
	import sprblt_pkg::*;

	cfg_t   cfg_q;
	logic   push, pop, full, empty;
	entry_t push_data, rd_data;
	logic [$bits(entry_t)-1:0] rd_bits;

	// register file; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= ORIGIN_RST;
			cfg_q.origin_y      <= ORIGIN_RST;
			cfg_q.zoom          <= ZOOM_RST;
			cfg_q.screen_width  <= SCR_W_RST;
			cfg_q.screen_height <= SCR_H_RST;
			cfg_q.sprite_width  <= SPR_W_RST;
			cfg_q.sprite_height <= SPR_H_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_ORIGIN_X:      cfg_q.origin_x      <= $signed(cfg_data[ORIGIN_W-1:0]);
				REG_ORIGIN_Y:      cfg_q.origin_y      <= $signed(cfg_data[ORIGIN_W-1:0]);
				REG_ZOOM:          cfg_q.zoom          <= cfg_data[ZOOM_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[SCREEN_W-1:0];
				REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[SPRITE_W-1:0];
				REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data[SPRITE_W-1:0];
				default: ;
			endcase
		end
	end

	// front: position tracking, alpha test and clipping of the square
	sprblt_front #(
		.MAX_ZOOM      (MAX_ZOOM),
		.MAX_SPRITE_DIM(MAX_SPRITE_DIM),
		.SCREEN_DIM    (SCREEN_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.texel_color(texel_color),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	// visible rectangles waiting for the back
	sprblt_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(push_data),
		.pop    (pop),
		.rd_data(rd_bits),
		.full   (full),
		.empty  (empty)
	);

	assign rd_data = entry_t'(rd_bits);

	// back: one screen write per cycle into the output register while not stalled
	sprblt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_data    (rd_data),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.run_last   (run_last)
	);

endmodule

FILE: hw/rtl/sprblt_checker.sv
// port-level checks of the scaled sprite blit unit, bound to the top level
// depends on sprblt_pkg and assert_macros.svh
`include "assert_macros.svh"

module sprblt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [sprblt_pkg::PIX_W-1:0]   pixel_x,
	input logic [sprblt_pkg::PIX_W-1:0]   pixel_y,
	input logic [sprblt_pkg::COLOR_W-1:0] pixel_color,
	input logic                           run_last
);
	import sprblt_pkg::*;

	logic out_take;
	assign out_take = out_valid && !out_stall;

	// a stalled word holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color))

	// only opaque texels are written
	`CHK_IMPLY(a_opaque, clk, arst_n, out_valid, pixel_color[COLOR_W-1:ALPHA_SHIFT] == '0)

	// a run continues without a gap until its last write
	`CHK_NEXT(a_run_gapless, clk, arst_n, out_take && !run_last, out_valid)

	// all writes of one run carry the same color
	`CHK_NEXT(a_run_color, clk, arst_n, out_take && !run_last,
		pixel_color == $past(pixel_color))

endmodule

bind scaled_sprite_blit_unit sprblt_checker u_checker (.*);
